FILE: src/kab_pkg.sv
// Shared types, constants and fixed-point helpers for the angle and bias filter.
// Used by the controller, the datapath, the divider and the top level.
`default_nettype none

package kab_pkg;

    // Field widths of the channels and the configuration port.
    localparam int AXIS_W  = 2;
    localparam int MEAS_W  = 19;
    localparam int GYRO_W  = 24;
    localparam int DT_W    = 16;
    localparam int EST_W   = 32;
    localparam int NOISE_W = 30;
    localparam int CFG_IDX_W = 2;

    // Working widths: saturation input and multiplier operands.
    localparam int SAT_W   = 40;
    localparam int MUL_A_W = 36;
    localparam int MUL_B_W = 33;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Fraction bits of the time step and of the covariance and gain format.
    localparam int DT_FRAC  = 16;
    localparam int COV_FRAC = 30;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_Q = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_Q  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_R  = 2'd2;

    // Configuration reset values (0.001, 0.003 and 0.03 in Q2.30).
    localparam logic [NOISE_W-1:0] ANGLE_Q_RST = 30'd1073742;
    localparam logic [NOISE_W-1:0] BIAS_Q_RST  = 30'd3221225;
    localparam logic [NOISE_W-1:0] MEAS_R_RST  = 30'd32212255;

    // Axis codes.
    localparam logic [AXIS_W-1:0] AXIS_ROLL  = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_PITCH = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_YAW   = 2'd2;
    localparam logic [AXIS_W-1:0] AXIS_NONE  = 2'd3;

    // Controller states.
    typedef enum logic [4:0] {
        ST_IDLE, ST_RATE, ST_D, ST_INNER, ST_PMUL, ST_QB, ST_P3, ST_DIVST, ST_DIV,
        ST_K, ST_U1, ST_U2, ST_U3, ST_U4, ST_U5, ST_U6, ST_U7, ST_WB
    } st_t;

    // Datapath operations, one for each working state.
    typedef enum logic [4:0] {
        OP_NOP, OP_RATE, OP_D, OP_INNER, OP_PMUL, OP_QB, OP_P3, OP_DIVST,
        OP_K, OP_U1, OP_U2, OP_U3, OP_U4, OP_U5, OP_U6, OP_U7
    } op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic wb;
        op_t  op;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic yaw;
        logic none;
        logic div_busy;
        logic out_busy;
    } stat_t;

    // Clamp a wide signed value to signed 32 bits.
    function automatic logic signed [EST_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [EST_W-1:0] r;
        if (v > 40'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (v < -40'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = v[EST_W-1:0];
        return r;
    endfunction

    // Round a product to nearest, ties upward, dropping s fraction bits.
    function automatic logic signed [SAT_W-1:0] rnd_sh(input logic signed [PROD_W-1:0] v,
                                                       input int unsigned s);
        logic signed [PROD_W-1:0] half;
        logic signed [PROD_W-1:0] t;
        half = 69'sd1 <<< (s - 1);
        t = v + half;
        return SAT_W'(t >>> s);
    endfunction

endpackage

`default_nettype wire

FILE: src/kab_div.sv
// Radix-2 restoring divider that forms one saturated Q2.30 gain.
// Depends on kab_pkg for widths.
`default_nettype none

module kab_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic signed [kab_pkg::EST_W-1:0] num,
    input  wire logic [kab_pkg::EST_W:0]       den,
    output logic                               busy,
    output logic signed [kab_pkg::EST_W-1:0]   k
);
    import kab_pkg::*;

    localparam int QW = EST_W + 1;
    localparam logic [5:0] STEPS = 6'(QW);

    logic [QW-1:0] rem_reg, rem_next;
    logic [QW-1:0] sh_reg, sh_next;
    logic [QW-1:0] q_reg, q_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic          neg_reg, neg_next;
    logic          ovf_reg, ovf_next;
    logic          busy_reg, busy_next;

    logic [EST_W-1:0] mag;
    logic [QW:0]      cat;
    logic [QW+1:0]    diff;
    logic             big;

    // Magnitude of the numerator and one trial subtraction.
    always_comb
    begin
        mag  = num[EST_W-1] ? (~num + 32'd1) : num;
        cat  = {rem_reg, sh_reg[QW-1]};
        diff = {1'b0, cat} - {2'b00, den};
    end

    // Start loads the upper dividend bits; each step brings in one more bit.
    // The quotient cannot fit in QW bits when those upper bits reach the divisor.
    always_comb
    begin
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        ovf_next  = ovf_reg;
        busy_next = busy_reg;
        if (start)
        begin
            neg_next  = num[EST_W-1];
            ovf_next  = ({4'd0, mag[EST_W-1:3]} >= den);
            rem_next  = {4'd0, mag[EST_W-1:3]};
            sh_next   = {mag[2:0], 30'd0};
            q_next    = '0;
            cnt_next  = STEPS;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[QW+1])
            begin
                rem_next = diff[QW-1:0];
                q_next   = {q_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = cat[QW-1:0];
                q_next   = {q_reg[QW-2:0], 1'b0};
            end
            sh_next  = {sh_reg[QW-2:0], 1'b0};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        q_reg   <= q_next;
        neg_reg <= neg_next;
        ovf_reg <= ovf_next;
    end

    // Signed, saturated gain from the quotient magnitude.
    always_comb
    begin
        big = ovf_reg | (q_reg[QW-1:QW-2] != 2'b00);
        if (neg_reg)
            k = big ? 32'sh8000_0000 : -$signed(q_reg[EST_W-1:0]);
        else
            k = big ? 32'sh7FFF_FFFF : $signed(q_reg[EST_W-1:0]);
    end

    assign busy = busy_reg;

endmodule

`default_nettype wire

FILE: src/kab_ctrl.sv
// Sequencing state machine for the filter: steps the datapath through one item.
// Depends on kab_pkg for the state, command and status types.
`default_nettype none

module kab_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire kab_pkg::stat_t stat,
    output kab_pkg::cmd_t       cmd
);
    import kab_pkg::*;

    st_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_valid) state_next = ST_RATE;
            ST_RATE:  state_next = stat.none ? ST_WB : ST_D;
            ST_D:     state_next = stat.yaw ? ST_WB : ST_INNER;
            ST_INNER: state_next = ST_PMUL;
            ST_PMUL:  state_next = ST_QB;
            ST_QB:    state_next = ST_P3;
            ST_P3:    state_next = ST_DIVST;
            ST_DIVST: state_next = ST_DIV;
            ST_DIV:   if (!stat.div_busy) state_next = ST_K;
            ST_K:     state_next = ST_U1;
            ST_U1:    state_next = ST_U2;
            ST_U2:    state_next = ST_U3;
            ST_U3:    state_next = ST_U4;
            ST_U4:    state_next = ST_U5;
            ST_U5:    state_next = ST_U6;
            ST_U6:    state_next = ST_U7;
            ST_U7:    state_next = ST_WB;
            ST_WB:    if (!stat.out_busy) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Commands and input handshake.
    always_comb
    begin
        cmd.load = 1'b0;
        cmd.wb   = 1'b0;
        cmd.op   = OP_NOP;
        in_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_RATE:  cmd.op = OP_RATE;
            ST_D:     cmd.op = OP_D;
            ST_INNER: cmd.op = OP_INNER;
            ST_PMUL:  cmd.op = OP_PMUL;
            ST_QB:    cmd.op = OP_QB;
            ST_P3:    cmd.op = OP_P3;
            ST_DIVST: cmd.op = OP_DIVST;
            ST_DIV:   cmd.op = OP_NOP;
            ST_K:     cmd.op = OP_K;
            ST_U1:    cmd.op = OP_U1;
            ST_U2:    cmd.op = OP_U2;
            ST_U3:    cmd.op = OP_U3;
            ST_U4:    cmd.op = OP_U4;
            ST_U5:    cmd.op = OP_U5;
            ST_U6:    cmd.op = OP_U6;
            ST_U7:    cmd.op = OP_U7;
            ST_WB:    cmd.wb = !stat.out_busy;
            default:  cmd.op = OP_NOP;
        endcase
    end

endmodule

`default_nettype wire

FILE: src/kab_dpath.sv
// Datapath of the filter: per-axis state, shared multiplier, two gain dividers,
// configuration registers and the output register. Depends on kab_pkg and kab_div.
`default_nettype none

module kab_dpath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire kab_pkg::cmd_t                     cmd,
    output kab_pkg::stat_t                         stat,
    input  wire logic [kab_pkg::AXIS_W-1:0]        axis,
    input  wire logic signed [kab_pkg::MEAS_W-1:0] measured_angle,
    input  wire logic signed [kab_pkg::GYRO_W-1:0] angular_rate,
    input  wire logic [kab_pkg::DT_W-1:0]          time_step,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [kab_pkg::AXIS_W-1:0]             axis_out,
    output logic signed [kab_pkg::EST_W-1:0]       angle_estimate,
    output logic signed [kab_pkg::EST_W-1:0]       bias_estimate,
    input  wire logic                              cfg_we,
    input  wire logic [kab_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [kab_pkg::NOISE_W-1:0]       cfg_data
);
    import kab_pkg::*;

    // Configuration registers.
    logic [NOISE_W-1:0] aq_reg, bq_reg, mr_reg;

    // Persistent per-axis state.
    logic signed [EST_W-1:0] ang_st_reg [3];
    logic signed [EST_W-1:0] bias_st_reg [3];
    logic signed [EST_W-1:0] cov_st_reg [8];

    // Working registers for the item in flight.
    logic [AXIS_W-1:0]         ax_reg, ax_next;
    logic signed [MEAS_W-1:0]  meas_reg, meas_next;
    logic signed [GYRO_W-1:0]  gyro_reg, gyro_next;
    logic [DT_W-1:0]           dt_reg, dt_next;
    logic signed [EST_W-1:0]   ang_reg, ang_next;
    logic signed [EST_W-1:0]   bias_reg, bias_next;
    logic signed [EST_W-1:0]   p0_reg, p0_next, p1_reg, p1_next;
    logic signed [EST_W-1:0]   p2_reg, p2_next, p3_reg, p3_next;
    logic signed [EST_W+1:0]   d_reg, d_next;
    logic signed [MUL_A_W-1:0] inner_reg, inner_next;
    logic signed [EST_W-1:0]   y_reg, y_next;
    logic signed [EST_W+1:0]   s_reg, s_next;
    logic                      spos_reg, spos_next;
    logic signed [EST_W-1:0]   k0_reg, k0_next, k1_reg, k1_next;
    logic signed [PROD_W-1:0]  prod_reg;

    // Output register.
    logic                    ov_reg;
    logic [AXIS_W-1:0]       oax_reg;
    logic signed [EST_W-1:0] oang_reg, obias_reg;

    // Multiplier operands and rounded products.
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod_w;
    logic signed [MUL_B_W-1:0] dt_s;
    logic signed [EST_W:0]     rate;
    logic signed [SAT_W-1:0]   r16, r30;
    logic                      div_start;
    logic signed [EST_W-1:0]   k0_div, k1_div;
    logic                      div0_busy;
    logic                      div1_busy;
    logic                      ax_valid, ax_kal;

    assign ax_valid = (ax_reg != AXIS_NONE);
    assign ax_kal   = (ax_reg == AXIS_ROLL) || (ax_reg == AXIS_PITCH);

    // Gain dividers: both run together on the same denominator.
    assign div_start = (cmd.op == OP_DIVST) && (s_reg > 34'sd0);

    kab_div u_div0 (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (p0_reg),
        .den   (s_reg[EST_W:0]),
        .busy  (div0_busy),
        .k     (k0_div)
    );

    kab_div u_div1 (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (p2_reg),
        .den   (s_reg[EST_W:0]),
        .busy  (div1_busy),
        .k     (k1_div)
    );

    // Operand selection for the shared multiplier.
    always_comb
    begin
        dt_s  = $signed({17'd0, dt_reg});
        rate  = 33'(gyro_reg) - 33'(bias_reg);
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_RATE:
            begin
                mul_a = 36'(rate);
                mul_b = dt_s;
            end
            OP_D:
            begin
                mul_a = 36'(p3_reg);
                mul_b = dt_s;
            end
            OP_PMUL:
            begin
                mul_a = inner_reg;
                mul_b = dt_s;
            end
            OP_QB:
            begin
                mul_a = $signed({6'd0, bq_reg});
                mul_b = dt_s;
            end
            OP_U1:
            begin
                mul_a = 36'(k0_reg);
                mul_b = 33'(y_reg);
            end
            OP_U2:
            begin
                mul_a = 36'(k1_reg);
                mul_b = 33'(y_reg);
            end
            OP_U3:
            begin
                mul_a = 36'(k0_reg);
                mul_b = 33'(p0_reg);
            end
            OP_U4:
            begin
                mul_a = 36'(k1_reg);
                mul_b = 33'(p0_reg);
            end
            OP_U5:
            begin
                mul_a = 36'(k0_reg);
                mul_b = 33'(p1_reg);
            end
            OP_U6:
            begin
                mul_a = 36'(k1_reg);
                mul_b = 33'(p1_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_w = mul_a * mul_b;
        r16    = rnd_sh(prod_reg, DT_FRAC);
        r30    = rnd_sh(prod_reg, COV_FRAC);
    end

    // Next values of the working registers.
    always_comb
    begin
        ax_next    = ax_reg;
        meas_next  = meas_reg;
        gyro_next  = gyro_reg;
        dt_next    = dt_reg;
        ang_next   = ang_reg;
        bias_next  = bias_reg;
        p0_next    = p0_reg;
        p1_next    = p1_reg;
        p2_next    = p2_reg;
        p3_next    = p3_reg;
        d_next     = d_reg;
        inner_next = inner_reg;
        y_next     = y_reg;
        s_next     = s_reg;
        spos_next  = spos_reg;
        k0_next    = k0_reg;
        k1_next    = k1_reg;
        if (cmd.load)
        begin
            ax_next   = axis;
            meas_next = measured_angle;
            gyro_next = angular_rate;
            dt_next   = time_step;
            ang_next  = (axis != AXIS_NONE) ? ang_st_reg[axis] : '0;
            bias_next = (axis != AXIS_NONE) ? bias_st_reg[axis] : '0;
            p0_next   = cov_st_reg[{axis[0], 2'd0}];
            p1_next   = cov_st_reg[{axis[0], 2'd1}];
            p2_next   = cov_st_reg[{axis[0], 2'd2}];
            p3_next   = cov_st_reg[{axis[0], 2'd3}];
        end
        case (cmd.op)
            OP_D:     ang_next = sat32(40'(ang_reg) + r16);
            OP_INNER:
            begin
                d_next     = 34'(r16);
                inner_next = 36'(r16) - 36'(p1_reg) - 36'(p2_reg) + $signed({6'd0, aq_reg});
            end
            OP_PMUL:
            begin
                p1_next = sat32(40'(p1_reg) - 40'(d_reg));
                p2_next = sat32(40'(p2_reg) - 40'(d_reg));
            end
            OP_QB:    p0_next = sat32(40'(p0_reg) + r16);
            OP_P3:
            begin
                p3_next = sat32(40'(p3_reg) + r16);
                y_next  = sat32(40'(meas_reg) - 40'(ang_reg));
                s_next  = 34'(p0_reg) + $signed({4'd0, mr_reg});
            end
            OP_DIVST: spos_next = (s_reg > 34'sd0);
            OP_K:
            begin
                k0_next = spos_reg ? k0_div : '0;
                k1_next = spos_reg ? k1_div : '0;
            end
            OP_U2:    ang_next  = sat32(40'(ang_reg) + r30);
            OP_U3:    bias_next = sat32(40'(bias_reg) + r30);
            OP_U4:    p0_next   = sat32(40'(p0_reg) - r30);
            OP_U5:    p2_next   = sat32(40'(p2_reg) - r30);
            OP_U6:    p1_next   = sat32(40'(p1_reg) - r30);
            OP_U7:    p3_next   = sat32(40'(p3_reg) - r30);
            default:  ang_next  = ang_next;
        endcase
    end

    // Working registers carry payload only.
    always_ff @(posedge clk)
    begin
        ax_reg    <= ax_next;
        meas_reg  <= meas_next;
        gyro_reg  <= gyro_next;
        dt_reg    <= dt_next;
        ang_reg   <= ang_next;
        bias_reg  <= bias_next;
        p0_reg    <= p0_next;
        p1_reg    <= p1_next;
        p2_reg    <= p2_next;
        p3_reg    <= p3_next;
        d_reg     <= d_next;
        inner_reg <= inner_next;
        y_reg     <= y_next;
        s_reg     <= s_next;
        spos_reg  <= spos_next;
        k0_reg    <= k0_next;
        k1_reg    <= k1_next;
        prod_reg  <= prod_w;
    end

    // Output payload is captured at write-back.
    always_ff @(posedge clk)
    begin
        if (cmd.wb)
        begin
            oax_reg   <= ax_reg;
            oang_reg  <= ang_reg;
            obias_reg <= bias_reg;
        end
    end

    // Persistent state, configuration and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aq_reg <= ANGLE_Q_RST;
            bq_reg <= BIAS_Q_RST;
            mr_reg <= MEAS_R_RST;
            ov_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                ang_st_reg[i]  <= '0;
                bias_st_reg[i] <= '0;
            end
            for (int i = 0; i < 8; i++)
                cov_st_reg[i] <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ANGLE_Q: aq_reg <= cfg_data;
                    CFG_BIAS_Q:  bq_reg <= cfg_data;
                    CFG_MEAS_R:  mr_reg <= cfg_data;
                    default:     aq_reg <= aq_reg;
                endcase
            end
            if (cmd.wb)
            begin
                ov_reg <= 1'b1;
                if (ax_valid)
                begin
                    ang_st_reg[ax_reg]  <= ang_reg;
                    bias_st_reg[ax_reg] <= bias_reg;
                end
                if (ax_kal)
                begin
                    cov_st_reg[{ax_reg[0], 2'd0}] <= p0_reg;
                    cov_st_reg[{ax_reg[0], 2'd1}] <= p1_reg;
                    cov_st_reg[{ax_reg[0], 2'd2}] <= p2_reg;
                    cov_st_reg[{ax_reg[0], 2'd3}] <= p3_reg;
                end
            end
            else if (ov_reg && !out_stall)
                ov_reg <= 1'b0;
        end
    end

    // Status back to the controller; the second divider runs in lockstep.
    always_comb
    begin
        stat.yaw      = (ax_reg == AXIS_YAW) && !div1_busy;
        stat.none     = !ax_valid;
        stat.div_busy = div0_busy;
        stat.out_busy = ov_reg && out_stall;
    end

    assign out_valid      = ov_reg;
    assign axis_out       = oax_reg;
    assign angle_estimate = oang_reg;
    assign bias_estimate  = obias_reg;

endmodule

`default_nettype wire

FILE: src/kalman_angle_bias_filter.sv
// Top level of the two-state angle and gyro bias filter.
// Depends on kab_pkg, kab_ctrl and kab_dpath.
//
// One transaction on the input channel carries an axis, an accelerometer angle, a gyro
// rate and a time step; exactly one result transaction follows with that axis's angle
// and bias. Roll and pitch items pass from acceptance to the result through the
// predict steps on the single shared multiplier, the 33-step radix-2 gain dividers that
// form both gains at once, the update steps on the multiplier and a write-back.
// Yaw skips the measurement update; axis code three gives zeros. One item is worked
// on at a time; the finished result sits in an output register, so the next item can
// be accepted while it waits. Configuration writes are always ready and must only be
// issued while the block is idle; a write to index three is ignored.
`default_nettype none

module kalman_angle_bias_filter (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [kab_pkg::AXIS_W-1:0]        axis,
    input  wire logic signed [kab_pkg::MEAS_W-1:0] measured_angle,
    input  wire logic signed [kab_pkg::GYRO_W-1:0] angular_rate,
    input  wire logic [kab_pkg::DT_W-1:0]          time_step,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [kab_pkg::AXIS_W-1:0]             axis_out,
    output logic signed [kab_pkg::EST_W-1:0]       angle_estimate,
    output logic signed [kab_pkg::EST_W-1:0]       bias_estimate,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [kab_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [kab_pkg::NOISE_W-1:0]       cfg_data
);
    import kab_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // Configuration writes complete in the cycle they are offered.
    assign cfg_ready = 1'b1;

    kab_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    kab_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .axis           (axis),
        .measured_angle (measured_angle),
        .angular_rate   (angular_rate),
        .time_step      (time_step),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .axis_out       (axis_out),
        .angle_estimate (angle_estimate),
        .bias_estimate  (bias_estimate),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

endmodule

`default_nettype wire

FILE: src/kab_chk.sv
// Port-level assertions for the filter top level, attached by a bind statement.
// Depends on kab_pkg for field widths and axis codes.
`default_nettype none

module kab_chk (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              in_valid,
    input wire logic                              in_stall,
    input wire logic                              out_valid,
    input wire logic                              out_stall,
    input wire logic [kab_pkg::AXIS_W-1:0]        axis_out,
    input wire logic signed [kab_pkg::EST_W-1:0]  angle_estimate,
    input wire logic signed [kab_pkg::EST_W-1:0]  bias_estimate
);
    import kab_pkg::*;

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its angle.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(angle_estimate))
        else $error("result angle changed while stalled");

    // Only one item is in work: after an accepted transaction the input is stalled.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second item accepted while one is in work");

    // The yaw bias is never updated, and an unknown axis reports zeros.
    a_yaw_bias: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (axis_out == AXIS_YAW || axis_out == AXIS_NONE) |-> bias_estimate == 0)
        else $error("non-zero bias on yaw or unknown axis");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && axis_out == AXIS_NONE |-> angle_estimate == 0)
        else $error("non-zero angle on unknown axis");

endmodule

bind kalman_angle_bias_filter kab_chk u_kab_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .axis_out       (axis_out),
    .angle_estimate (angle_estimate),
    .bias_estimate  (bias_estimate)
);

`default_nettype wire

FILE: tb/sv/kalman_angle_bias_filter_checker.sv
// Checker for the angle and bias filter: watches the input, result and configuration
// channels, predicts each result and compares it. Depends on kab_pkg.
`default_nettype none

module kalman_angle_bias_filter_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    input  wire logic                              in_stall,
    input  wire logic [kab_pkg::AXIS_W-1:0]        axis,
    input  wire logic signed [kab_pkg::MEAS_W-1:0] measured_angle,
    input  wire logic signed [kab_pkg::GYRO_W-1:0] angular_rate,
    input  wire logic [kab_pkg::DT_W-1:0]          time_step,
    input  wire logic                              out_valid,
    input  wire logic                              out_stall,
    input  wire logic [kab_pkg::AXIS_W-1:0]        axis_out,
    input  wire logic signed [kab_pkg::EST_W-1:0]  angle_estimate,
    input  wire logic signed [kab_pkg::EST_W-1:0]  bias_estimate,
    input  wire logic                              cfg_valid,
    input  wire logic                              cfg_ready,
    input  wire logic [kab_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [kab_pkg::NOISE_W-1:0]       cfg_data,
    output int                                     mismatches,
    output int                                     outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import kab_pkg::*;

    typedef struct {
        logic [AXIS_W-1:0]       axis;
        logic signed [EST_W-1:0] angle;
        logic signed [EST_W-1:0] bias;
    } estimate_t;

    // Model copy of the filter state and the noise settings.
    logic [NOISE_W-1:0] angle_noise;
    logic [NOISE_W-1:0] bias_noise;
    logic [NOISE_W-1:0] meas_noise;
    int                 angle_est [3];
    int                 bias_est [3];
    int                 covariance [8];
    estimate_t          pending_estimates [$];

    function automatic int clamp_word(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return int'(v);
    endfunction

    // Round to nearest with ties upward, then drop s fraction bits.
    function automatic longint round_drop(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    // Q2.30 gain, truncated toward zero and limited.
    function automatic int gain_quotient(input int num, input longint den);
        logic                neg;
        longint unsigned     mag;
        longint unsigned     q;
        neg = num < 0;
        mag = neg ? longint'(-longint'(num)) : longint'(num);
        q = (mag << COV_FRAC) / longint'(den);
        if (q > (64'd1 << 32))
            q = 64'd1 << 32;
        return clamp_word(neg ? -longint'(q) : longint'(q));
    endfunction

    // Advance one axis by one sample and return the estimate that it produces.
    function automatic estimate_t filter_sample(input logic [AXIS_W-1:0] ax,
                                                input longint meas, input longint gyro,
                                                input longint dt);
        estimate_t r;
        longint    d, inner, y, s, p00, p01, p10, p11;
        int        k0, k1, base;
        if (ax == AXIS_NONE) begin
            r.axis = AXIS_NONE;
            r.angle = '0;
            r.bias = '0;
            return r;
        end
        angle_est[ax] = clamp_word(longint'(angle_est[ax]) +
                                   round_drop((gyro - longint'(bias_est[ax])) * dt, DT_FRAC));
        if (ax != AXIS_YAW) begin
            base = ax * 4;
            p00 = covariance[base];
            p01 = covariance[base + 1];
            p10 = covariance[base + 2];
            p11 = covariance[base + 3];
            d = round_drop(dt * p11, DT_FRAC);
            inner = d - p01 - p10 + longint'(angle_noise);
            covariance[base]     = clamp_word(p00 + round_drop(dt * inner, DT_FRAC));
            covariance[base + 1] = clamp_word(p01 - d);
            covariance[base + 2] = clamp_word(p10 - d);
            covariance[base + 3] = clamp_word(p11 + round_drop(longint'(bias_noise) * dt,
                                                                DT_FRAC));
            // Measurement update; the gains stay zero when S is not positive.
            y = clamp_word(meas - longint'(angle_est[ax]));
            s = longint'(covariance[base]) + longint'(meas_noise);
            k0 = 0;
            k1 = 0;
            if (s > 0) begin
                k0 = gain_quotient(covariance[base], s);
                k1 = gain_quotient(covariance[base + 2], s);
            end
            angle_est[ax] = clamp_word(longint'(angle_est[ax]) +
                                       round_drop(longint'(k0) * y, COV_FRAC));
            bias_est[ax] = clamp_word(longint'(bias_est[ax]) +
                                      round_drop(longint'(k1) * y, COV_FRAC));
            p00 = covariance[base];
            p01 = covariance[base + 1];
            covariance[base] = clamp_word(p00 - round_drop(longint'(k0) * p00, COV_FRAC));
            covariance[base + 1] = clamp_word(p01 - round_drop(longint'(k0) * p01, COV_FRAC));
            covariance[base + 2] = clamp_word(longint'(covariance[base + 2]) -
                                              round_drop(longint'(k1) * p00, COV_FRAC));
            covariance[base + 3] = clamp_word(longint'(covariance[base + 3]) -
                                              round_drop(longint'(k1) * p01, COV_FRAC));
        end
        r.axis = ax;
        r.angle = angle_est[ax];
        r.bias = bias_est[ax];
        return r;
    endfunction

    // Compare each result transaction, then predict from each input transaction.
    always @(posedge clk or negedge rst_n)
    begin
        estimate_t want;
        if (!rst_n) begin
            angle_noise = ANGLE_Q_RST;
            bias_noise = BIAS_Q_RST;
            meas_noise = MEAS_R_RST;
            angle_est = '{default: 0};
            bias_est = '{default: 0};
            covariance = '{default: 0};
            pending_estimates.delete();
            mismatches = 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (pending_estimates.size() == 0) begin
                    $error("result transaction with no estimate expected");
                    mismatches++;
                end else begin
                    want = pending_estimates.pop_front();
                    if (axis_out !== want.axis) begin
                        $error("axis_out: expected %0d, got %0d", want.axis, axis_out);
                        mismatches++;
                    end
                    if (angle_estimate !== want.angle) begin
                        $error("angle_estimate: expected %0d, got %0d",
                               want.angle, angle_estimate);
                        mismatches++;
                    end
                    if (bias_estimate !== want.bias) begin
                        $error("bias_estimate: expected %0d, got %0d",
                               want.bias, bias_estimate);
                        mismatches++;
                    end
                end
            end
            if (in_valid && !in_stall)
                pending_estimates.push_back(filter_sample(axis, longint'(measured_angle),
                                                          longint'(angular_rate),
                                                          longint'(time_step)));
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_ANGLE_Q: angle_noise = cfg_data;
                    CFG_BIAS_Q:  bias_noise = cfg_data;
                    CFG_MEAS_R:  meas_noise = cfg_data;
                    default: ;
                endcase
            end
        end
        outstanding = pending_estimates.size();
    end

endmodule

`default_nettype wire

FILE: tb/sv/kalman_angle_bias_filter_test.sv
// Top of the angle and bias filter testbench: clock, reset, stimulus and verdict.
// Depends on kab_pkg, kalman_angle_bias_filter and kalman_angle_bias_filter_checker.
`default_nettype none

module kalman_angle_bias_filter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import kab_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int PHASES = 6;
    localparam int ITEMS_PER_PHASE = 290;
    localparam int HOLD_CYCLES = 400;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic [AXIS_W-1:0]       axis;
    logic signed [MEAS_W-1:0] measured_angle;
    logic signed [GYRO_W-1:0] angular_rate;
    logic [DT_W-1:0]         time_step;
    logic                    out_valid;
    logic                    out_stall;
    logic [AXIS_W-1:0]       axis_out;
    logic signed [EST_W-1:0] angle_estimate;
    logic signed [EST_W-1:0] bias_estimate;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [NOISE_W-1:0]      cfg_data;
    int                      mismatches;
    int                      outstanding;
    int                      samples_sent;
    logic                    quiet_tail;

    kalman_angle_bias_filter dut (.*);

    kalman_angle_bias_filter_checker checker_inst (.*);

    // Clock and a single reset at the start.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Overall time limit.
    initial
    begin
        #40ms;
        $display("simulation failed");
        $finish;
    end

    // Result side: random stall bursts, one long hold-off, none in the tail.
    initial
    begin
        bit held;
        int n;
        held = 0;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (!held && samples_sent >= 300) begin
                held = 1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 6);
                out_stall <= 1'b1;
                repeat (n - 1) @(negedge clk);
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // One input transaction, held until it is taken.
    task automatic send_sample(input logic [AXIS_W-1:0] ax, input logic [MEAS_W-1:0] meas,
                               input logic [GYRO_W-1:0] gyro, input logic [DT_W-1:0] dt);
        @(negedge clk);
        in_valid <= 1'b1;
        axis <= ax;
        measured_angle <= meas;
        angular_rate <= gyro;
        time_step <= dt;
        do @(posedge clk); while (in_stall);
        samples_sent++;
    endtask

    // Idle the input for a random burst, sometimes.
    task automatic input_gap();
        int n;
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 6);
            repeat (n) begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [NOISE_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (outstanding == 0);
    endtask

    // Random sample: mostly plausible motion, some raw noise over every bit.
    task automatic random_sample();
        logic [AXIS_W-1:0] ax;
        logic [MEAS_W-1:0] meas;
        logic [GYRO_W-1:0] gyro;
        logic [DT_W-1:0]   dt;
        ax = ($urandom_range(0, 9) == 0) ? AXIS_NONE : AXIS_W'($urandom_range(0, 2));
        if ($urandom_range(0, 9) == 0) begin
            meas = MEAS_W'($urandom);
            gyro = GYRO_W'($urandom);
            dt = DT_W'($urandom);
        end else begin
            meas = MEAS_W'(int'($urandom_range(0, 411776)) - 205888);
            gyro = GYRO_W'(int'($urandom_range(0, 262144)) - 131072);
            dt = DT_W'($urandom_range(0, 1400));
        end
        send_sample(ax, meas, gyro, dt);
        input_gap();
    endtask

    initial
    begin
        in_valid = 1'b0;
        axis = '0;
        measured_angle = '0;
        angular_rate = '0;
        time_step = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        samples_sent = 0;
        quiet_tail = 1'b0;
        @(posedge rst_n);

        // Directed samples at reset settings: field extremes and every axis code.
        send_sample(AXIS_ROLL, 19'sd205888, 24'sd0, 16'd655);
        send_sample(AXIS_ROLL, -19'sd205888, 24'sh7FFFFF, 16'hFFFF);
        send_sample(AXIS_ROLL, 19'sh3FFFF, 24'sh800000, 16'hFFFF);
        send_sample(AXIS_PITCH, 19'sh40000, 24'sh800000, 16'd0);
        send_sample(AXIS_PITCH, 19'sd1000, 24'sd65536, 16'd65);
        send_sample(AXIS_PITCH, -19'sd1, -24'sd1, 16'd1);
        send_sample(AXIS_YAW, 19'sd205888, 24'sh7FFFFF, 16'hFFFF);
        send_sample(AXIS_YAW, -19'sd205888, 24'sh800000, 16'hFFFF);
        send_sample(AXIS_YAW, 19'sd0, 24'sd100, 16'd0);
        send_sample(AXIS_NONE, 19'sh3FFFF, 24'sh7FFFFF, 16'hFFFF);
        send_sample(AXIS_NONE, 19'sh40000, 24'sh800000, 16'd0);
        repeat (6) send_sample(AXIS_ROLL, 19'sd0, 24'sh7FFFFF, 16'hFFFF);
        repeat (4) send_sample(AXIS_PITCH, 19'sd205888, 24'sh800000, 16'hFFFF);
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            // Settings for this phase, written while the block is idle.
            case (ph)
                1: begin
                    write_reg(CFG_ANGLE_Q, '0);
                    write_reg(CFG_BIAS_Q, '0);
                    write_reg(CFG_MEAS_R, 30'd1);
                end
                2: begin
                    write_reg(CFG_ANGLE_Q, '1);
                    write_reg(CFG_BIAS_Q, '1);
                    write_reg(CFG_MEAS_R, '1);
                end
                3, 4: begin
                    write_reg(CFG_SPARE, NOISE_W'($urandom));
                    write_reg(CFG_ANGLE_Q, NOISE_W'($urandom));
                    write_reg(CFG_BIAS_Q, NOISE_W'($urandom));
                    write_reg(CFG_MEAS_R, NOISE_W'($urandom_range(1, 32'h3FFFFFFF)));
                end
                5: begin
                    write_reg(CFG_ANGLE_Q, ANGLE_Q_RST);
                    write_reg(CFG_BIAS_Q, BIAS_Q_RST);
                    write_reg(CFG_MEAS_R, MEAS_R_RST);
                    quiet_tail = 1'b1;
                end
                default: ;
            endcase
            repeat (ITEMS_PER_PHASE) random_sample();
            drain();
        end

        // Let any late result show itself, then give the verdict.
        repeat (80) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
